>>> src/sncdg_pkg.sv
`timescale 1ns / 1ps
// sncdg_pkg: constants, field widths and helper functions for the node config
// datagram generator. No dependencies.
package sncdg_pkg;

    localparam int unsigned NodeWidth    = 2;
    localparam int unsigned MicroWidth   = 9;
    localparam int unsigned CurrentWidth = 5;
    localparam int unsigned ByteWidth    = 8;
    localparam int unsigned MresWidth    = 4;

    localparam int unsigned DgramLen   = 8;
    localparam int unsigned TotalBytes = 24;
    localparam int unsigned IdxWidth   = $clog2(TotalBytes);
    localparam int unsigned PosWidth   = $clog2(DgramLen);

    localparam logic [7:0] SyncByte   = 8'h05;
    localparam logic [7:0] WriteFlag  = 8'h80;
    localparam logic [7:0] CrcPoly    = 8'h07;
    localparam logic [7:0] RegGlobal  = 8'h00;
    localparam logic [7:0] RegChopper = 8'h6C;
    localparam logic [7:0] RegCurrent = 8'h10;

    localparam logic [31:0] GlobalData = 32'h0000_00C1;
    localparam logic [31:0] ChopBase   = 32'h1000_0053;
    localparam logic [31:0] ChopInterp = 32'h1000_0000;
    localparam logic [7:0]  HoldDelay  = 8'd6;

    // datagram slots within one request
    typedef enum logic [1:0] {
        DG_GLOBAL  = 2'd0,
        DG_CHOPPER = 2'd1,
        DG_CURRENT = 2'd2
    } dgram_sel_t;

    // byte positions within one datagram
    localparam logic [PosWidth-1:0] PosSync  = 3'd0;
    localparam logic [PosWidth-1:0] PosNode  = 3'd1;
    localparam logic [PosWidth-1:0] PosReg   = 3'd2;
    localparam logic [PosWidth-1:0] PosData3 = 3'd3;
    localparam logic [PosWidth-1:0] PosData2 = 3'd4;
    localparam logic [PosWidth-1:0] PosData1 = 3'd5;
    localparam logic [PosWidth-1:0] PosData0 = 3'd6;
    localparam logic [PosWidth-1:0] PosCrc   = 3'd7;

    // microstep count to resolution code, anything else maps to 16 microsteps
    function automatic logic [MresWidth-1:0] resolution_code(
        input logic [MicroWidth-1:0] ms
    );
        logic [MresWidth-1:0] code;
        begin
            unique case (ms)
                9'd256:  code = 4'd0;
                9'd128:  code = 4'd1;
                9'd64:   code = 4'd2;
                9'd32:   code = 4'd3;
                9'd16:   code = 4'd4;
                9'd8:    code = 4'd5;
                9'd4:    code = 4'd6;
                9'd2:    code = 4'd7;
                9'd1:    code = 4'd8;
                default: code = 4'd4;
            endcase
            return code;
        end
    endfunction

    // one byte of crc8, data taken lsb first
    function automatic logic [7:0] crc8_byte(
        input logic [7:0] crc_in,
        input logic [7:0] data
    );
        logic [7:0] crc;
        begin
            crc = crc_in;
            for (int b = 0; b < 8; b++) begin
                if ((crc[7] ^ data[b]) == 1'b1) begin
                    crc = {crc[6:0], 1'b0} ^ CrcPoly;
                end
                else begin
                    crc = {crc[6:0], 1'b0};
                end
            end
            return crc;
        end
    endfunction

endpackage

>>> src/sncdg_if.sv
`timescale 1ns / 1ps
// sncdg_req_if / sncdg_tx_if: valid/ready channels for requests and
// datagram bytes. Depends on sncdg_pkg for field widths.
interface sncdg_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [sncdg_pkg::NodeWidth-1:0]      node_address;
    logic [sncdg_pkg::MicroWidth-1:0]     microstep_count;
    logic [sncdg_pkg::CurrentWidth-1:0]   run_current;
    logic [sncdg_pkg::CurrentWidth-1:0]   hold_current;

    modport source (
        output valid, node_address, microstep_count, run_current, hold_current,
        input  ready
    );
    modport sink (
        input  valid, node_address, microstep_count, run_current, hold_current,
        output ready
    );
endinterface

interface sncdg_tx_if;
    logic                              valid;
    logic                              ready;
    logic [sncdg_pkg::ByteWidth-1:0]   tx_byte;
    logic                              last_byte;

    modport source (
        output valid, tx_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, last_byte,
        output ready
    );
endinterface

>>> src/stepper_node_config_datagram_gen_unit.sv
`timescale 1ns / 1ps
// stepper_node_config_datagram_gen_unit: turns one node request into three
// 8-byte write datagrams (24 bytes). Depends on sncdg_pkg and sncdg_if.
// start: accepting sets the busy flag, then the first byte is loaded into the output register
// one byte a cycle through the single output register while the output is not stalled
// the next request is taken in the cycle the 24th byte is loaded, so requests stream gap-free
// reset: asynchronous, active low; clears the busy flag, byte index, crc and output valid
module stepper_node_config_datagram_gen_unit (
    input  logic             clk,
    input  logic             rst_n,
    sncdg_req_if.sink        req,
    sncdg_tx_if.source       dgram
);

    localparam logic [sncdg_pkg::IdxWidth-1:0] LastIdx =
        sncdg_pkg::IdxWidth'(sncdg_pkg::TotalBytes - 1);
    localparam logic [sncdg_pkg::IdxWidth-1:0] IdxStep =
        sncdg_pkg::IdxWidth'(1);

    // request held for the whole 24-byte run
    logic [sncdg_pkg::NodeWidth-1:0]    node_reg;
    logic [sncdg_pkg::MresWidth-1:0]    mres_reg;
    logic [sncdg_pkg::CurrentWidth-1:0] irun_reg;
    logic [sncdg_pkg::CurrentWidth-1:0] ihold_reg;

    // run control
    logic                               active_reg, active_next;
    logic [sncdg_pkg::IdxWidth-1:0]     idx_reg, idx_next;
    logic [7:0]                         crc_reg, crc_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    logic [7:0]                         out_byte_reg;
    logic                               out_last_reg;

    logic                               out_free;
    logic                               emit;
    logic                               last_emit;
    logic                               accept;

    sncdg_pkg::dgram_sel_t              dgram_sel;
    logic [sncdg_pkg::PosWidth-1:0]     pos;
    logic [7:0]                         reg_addr;
    logic [31:0]                        data_word;
    logic [7:0]                         cur_byte;

    // handshake: a byte moves whenever the output register is empty or drains
    assign out_free  = !out_valid_reg || dgram.ready;
    assign emit      = active_reg && out_free;
    assign last_emit = emit && (idx_reg == LastIdx);
    assign req.ready = !active_reg || last_emit;
    assign accept    = req.valid && req.ready;

    // datagram slot and position within it
    assign dgram_sel = sncdg_pkg::dgram_sel_t'(idx_reg[sncdg_pkg::IdxWidth-1 -: 2]);
    assign pos       = idx_reg[sncdg_pkg::PosWidth-1:0];

    // register address and data word of the current datagram
    always_comb
    begin
        unique case (dgram_sel)
            sncdg_pkg::DG_GLOBAL:
            begin
                reg_addr  = sncdg_pkg::RegGlobal;
                data_word = sncdg_pkg::GlobalData;
            end
            sncdg_pkg::DG_CHOPPER:
            begin
                reg_addr  = sncdg_pkg::RegChopper;
                data_word = sncdg_pkg::ChopBase | sncdg_pkg::ChopInterp
                          | {4'b0, mres_reg, 24'b0};
            end
            sncdg_pkg::DG_CURRENT:
            begin
                reg_addr  = sncdg_pkg::RegCurrent;
                data_word = {8'b0, sncdg_pkg::HoldDelay, 3'b0, irun_reg, 3'b0, ihold_reg};
            end
            default:
            begin
                reg_addr  = sncdg_pkg::RegGlobal;
                data_word = sncdg_pkg::GlobalData;
            end
        endcase
    end

    // byte mux: header, data msb first, crc at the end
    always_comb
    begin
        unique case (pos)
            sncdg_pkg::PosSync:  cur_byte = sncdg_pkg::SyncByte;
            sncdg_pkg::PosNode:  cur_byte = {6'b0, node_reg};
            sncdg_pkg::PosReg:   cur_byte = reg_addr | sncdg_pkg::WriteFlag;
            sncdg_pkg::PosData3: cur_byte = data_word[31:24];
            sncdg_pkg::PosData2: cur_byte = data_word[23:16];
            sncdg_pkg::PosData1: cur_byte = data_word[15:8];
            sncdg_pkg::PosData0: cur_byte = data_word[7:0];
            sncdg_pkg::PosCrc:   cur_byte = crc_reg;
            default:             cur_byte = crc_reg;
        endcase
    end

    // next-state logic
    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;

        if (dgram.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + IdxStep;
            // crc restarts after every datagram's crc byte goes out
            if (pos == sncdg_pkg::PosCrc)
            begin
                crc_next = 8'h00;
            end
            else
            begin
                crc_next = sncdg_pkg::crc8_byte(crc_reg, cur_byte);
            end
            if (last_emit)
            begin
                active_next = 1'b0;
            end
        end

        // a new request starts a fresh run, even on the last byte of the old one
        if (accept)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            crc_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            node_reg  <= req.node_address;
            mres_reg  <= sncdg_pkg::resolution_code(req.microstep_count);
            irun_reg  <= req.run_current;
            ihold_reg <= req.hold_current;
        end
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= (idx_reg == LastIdx);
        end
    end

    assign dgram.valid     = out_valid_reg;
    assign dgram.tx_byte   = out_byte_reg;
    assign dgram.last_byte = out_last_reg;

endmodule
